// File: design/exponential_search_sorted_table_macros.svh
// Assertion macros for the exponential search block.
`ifndef EXPONENTIAL_SEARCH_SORTED_TABLE_MACROS_SVH
`define EXPONENTIAL_SEARCH_SORTED_TABLE_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define ESS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ESS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: design/ess_pkg.sv
`default_nettype none

package ess_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned POS_W           = 10;
  localparam int unsigned COUNT_W         = 11;
  localparam int unsigned DATA_W          = 32;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef struct packed {
    logic                     command;
    logic [POS_W-1:0]         address;
    logic signed [DATA_W-1:0] element_value;
    logic signed [DATA_W-1:0] search_key;
  } in_word_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } out_word_t;

  // three-way compare flags of table entry against key
  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ZERO,
    ST_DBL,
    ST_BSET,
    ST_BIN
  } state_e;

endpackage

`default_nettype wire

// File: design/exponential_search_sorted_table.sv
`default_nettype none

// Sorted-table exponential search. A word with command = write stores
// element_value at address (addresses at or above TABLE_DEPTH are
// dropped) and gives no result; busy stays low. A search word holds busy
// high while the sequencer probes the table through its single read port,
// one entry per cycle: first entry 0, then the doubling probes, then a
// step that sets up the binary range, then the binary probes. An empty
// table answers without any probe. Each search gives exactly one result,
// shown on out_word_o with done_o high for a single cycle; there is no
// back-pressure, so the receiver must take it then. The user must see that
// entry_count is written on the config channel (always ready) only while
// the block is idle; the block itself does not enforce it. Counts above
// TABLE_DEPTH saturate. Entries must be written before a search can reach
// them; the table has no reset.
module exponential_search_sorted_table #(
  parameter int unsigned TABLE_DEPTH = ess_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  ess_pkg::in_word_t            in_word_i,
  output logic                         done_o,
  output ess_pkg::out_word_t           out_word_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ess_pkg::COUNT_W-1:0]  cfg_data_i
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned BW = AW + 2;

  ess_pkg::state_e state_q, state_d;

  logic [NW-1:0]                   n_q;
  logic signed [ess_pkg::DATA_W-1:0] mem [TABLE_DEPTH];
  logic signed [ess_pkg::DATA_W-1:0] rdata_q;
  logic signed [ess_pkg::DATA_W-1:0] key_q, key_d;
  logic [AW-1:0]                   raddr;
  logic                            mem_we;

  logic [BW-1:0] bound_q, bound_d, bound_dbl;
  logic [AW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, mid_calc;
  logic          issue_mid;

  logic                     done_q, done_d;
  logic                     found_q, found_d;
  logic [ess_pkg::POS_W-1:0] pos_q, pos_d;

  ess_pkg::cmp_t cmp;

  ess_cmp u_cmp (
    .entry_i (rdata_q),
    .key_i   (key_q),
    .res_o   (cmp)
  );

  assign busy        = (state_q != ess_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign out_word_o.found    = found_q;
  assign out_word_o.position = pos_q;

  assign mem_we = start && !busy && (in_word_i.command == ess_pkg::CMD_WRITE)
                  && (32'(in_word_i.address) < TABLE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[AW'(in_word_i.address)] <= in_word_i.element_value;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ess_pkg::ST_IDLE;
      done_q  <= 1'b0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        n_q <= (32'(cfg_data_i) > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : NW'(cfg_data_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    bound_q <= bound_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    found_q <= found_d;
    pos_q   <= pos_d;
  end

  assign bound_dbl = bound_q << 1;

  always_comb begin
    state_d   = state_q;
    key_d     = key_q;
    bound_d   = bound_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    raddr     = '0;
    issue_mid = 1'b0;
    done_d    = 1'b0;
    found_d   = found_q;
    pos_d     = pos_q;

    unique case (state_q)
      ess_pkg::ST_IDLE: begin
        if (start && (in_word_i.command == ess_pkg::CMD_SEARCH)) begin
          key_d = in_word_i.search_key;
          if (n_q == '0) begin
            done_d  = 1'b1;
            found_d = 1'b0;
            pos_d   = '0;
          end else begin
            raddr   = '0;
            state_d = ess_pkg::ST_ZERO;
          end
        end
      end
      ess_pkg::ST_ZERO: begin
        if (cmp.eq) begin
          done_d  = 1'b1;
          found_d = 1'b1;
          pos_d   = '0;
          state_d = ess_pkg::ST_IDLE;
        end else begin
          bound_d = BW'(1);
          if (BW'(1) < BW'(n_q)) begin
            raddr   = AW'(1);
            state_d = ess_pkg::ST_DBL;
          end else begin
            state_d = ess_pkg::ST_BSET;
          end
        end
      end
      ess_pkg::ST_DBL: begin
        // entry at bound is not above the key: keep doubling
        if (cmp.eq || cmp.lt) begin
          bound_d = bound_dbl;
          if (bound_dbl < BW'(n_q)) begin
            raddr = AW'(bound_dbl);
          end else begin
            state_d = ess_pkg::ST_BSET;
          end
        end else begin
          state_d = ess_pkg::ST_BSET;
        end
      end
      ess_pkg::ST_BSET: begin
        // range is never empty here: bound/2 < count
        lo_d = AW'(bound_q >> 1);
        hi_d = (bound_q < (BW'(n_q) - BW'(1))) ? AW'(bound_q) : AW'(n_q - NW'(1));
        issue_mid = 1'b1;
        state_d   = ess_pkg::ST_BIN;
      end
      ess_pkg::ST_BIN: begin
        if (cmp.eq) begin
          done_d  = 1'b1;
          found_d = 1'b1;
          pos_d   = ess_pkg::POS_W'(mid_q);
          state_d = ess_pkg::ST_IDLE;
        end else if (cmp.lt) begin
          if (mid_q == hi_q) begin
            done_d  = 1'b1;
            found_d = 1'b0;
            pos_d   = '0;
            state_d = ess_pkg::ST_IDLE;
          end else begin
            lo_d      = mid_q + AW'(1);
            issue_mid = 1'b1;
          end
        end else begin
          if (mid_q == lo_q) begin
            done_d  = 1'b1;
            found_d = 1'b0;
            pos_d   = '0;
            state_d = ess_pkg::ST_IDLE;
          end else begin
            hi_d      = mid_q - AW'(1);
            issue_mid = 1'b1;
          end
        end
      end
      default: begin
        state_d = ess_pkg::ST_IDLE;
      end
    endcase

    mid_calc = lo_d + ((hi_d - lo_d) >> 1);
    if (issue_mid) begin
      raddr = mid_calc;
      mid_d = mid_calc;
    end
  end

endmodule

`default_nettype wire

// File: design/ess_cmp.sv
`default_nettype none

// Shared signed comparator: every probe of the search goes through it.
module ess_cmp (
  input  logic signed [ess_pkg::DATA_W-1:0] entry_i,
  input  logic signed [ess_pkg::DATA_W-1:0] key_i,
  output ess_pkg::cmp_t                     res_o
);

  assign res_o.eq = (entry_i == key_i);
  assign res_o.lt = (entry_i < key_i);

endmodule

`default_nettype wire

// File: design/ess_chk.sv
`default_nettype none

`include "exponential_search_sorted_table_macros.svh"

module ess_chk (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire ess_pkg::in_word_t  in_word_i,
  input wire logic               done_o,
  input wire ess_pkg::out_word_t out_word_o
);

  `ESS_ASSERT(a_miss_pos_zero, done_o && !out_word_o.found |-> out_word_o.position == '0, "miss with nonzero position")

  `ESS_ASSERT(a_write_silent, start && !busy && in_word_i.command == ess_pkg::CMD_WRITE |=> !done_o && !busy, "write word produced a result or went busy")

  `ESS_ASSERT(a_search_acts, start && !busy && in_word_i.command == ess_pkg::CMD_SEARCH |=> busy || done_o, "search word was dropped")

  `ESS_ASSERT(a_busy_from_start, $rose(busy) |-> $past(start), "busy rose without a start")

  `ESS_ASSERT(a_done_idle, done_o |-> !busy, "result shown while still busy")

endmodule

bind exponential_search_sorted_table ess_chk u_ess_chk (.*);

`default_nettype wire
